// ===== rtl/hnd_pkg.sv =====
// Shared types, constants and the CRC helper of the HDLC NRZI deframer.
package hnd_pkg;

  // Reflected CRC-CCITT
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_GOOD   = 16'hF0B8;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  // Framing
  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] WINDOW_RESET = 8'hFF;

  localparam int unsigned LEN_W        = 12;
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 12'd330;
  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 12'd4;
  localparam logic [LEN_W-1:0] CRC_BYTES       = 12'd2;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // End of frame status codes
  typedef enum logic [2:0] {
    ST_GOOD  = 3'd0,
    ST_CRC   = 3'd1,
    ST_SHORT = 3'd2,
    ST_ALIGN = 3'd3,
    ST_ABORT = 3'd4,
    ST_LONG  = 3'd5
  } hnd_status_t;

  // One classified line bit, passed from front to back
  typedef struct packed {
    logic is_flag;
    logic bit_val;
  } hnd_evt_t;

  // One result item
  typedef struct packed {
    logic             is_end;
    logic [7:0]       data_byte;
    hnd_status_t      status;
    logic [LEN_W-1:0] length;
  } hnd_result_t;

  // Run one byte, LSB first, through the reflected CRC
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/hdlc_nrzi_deframer.sv =====
// Top level of the HDLC NRZI deframer: front end, event queue and back end.
//
// Receives one NRZI line bit per input beat (no level change decodes as 1),
// finds 0x7E flags, removes stuffed zeros, packs bytes LSB first and checks
// the reflected CRC-CCITT. Data bytes come out two bytes late, so the CRC
// bytes never appear; each frame ends with a status beat (tuser high) that
// carries good, CRC error, too short, misaligned, aborted or too long, and
// on a good frame the length without CRC. The block takes one bit per clock
// cycle while the receiver keeps up: the front end decodes each accepted bit,
// the back end retires one queued bit per cycle, and a result register holds
// a pending beat while the queue keeps taking bits until it fills. A result
// beat passes through the event queue and then the result register before
// out_tvalid shows it. The frame size limit must be written through
// cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce it.
module hdlc_nrzi_deframer #(
  parameter int unsigned QUEUE_DEPTH = hnd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [hnd_pkg::LEN_W-1:0] cfg_wr_data,  // max_frame_bytes
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,     // [0] line_level, [7:1] zero
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,    // [7:0] data_byte, [10:8] frame_status,
                                                  // [22:11] frame_length, [23] zero
  output logic                      out_tuser     // is_frame_end
);
  import hnd_pkg::*;

  logic        push;
  hnd_evt_t    push_evt;
  logic        queue_full;
  logic        queue_empty;
  logic        pop;
  hnd_evt_t    pop_evt;
  hnd_result_t result;

  hnd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .line_level (in_tdata[0]),
    .push       (push),
    .push_evt   (push_evt),
    .queue_full (queue_full)
  );

  hnd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .full     (queue_full),
    .pop      (pop),
    .pop_evt  (pop_evt),
    .empty    (queue_empty)
  );

  hnd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .queue_empty (queue_empty),
    .evt         (pop_evt),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .result      (result)
  );

  // Pack the result beat
  assign out_tdata = {1'b0, result.length, result.status, result.data_byte};
  assign out_tuser = result.is_end;

endmodule

// ===== rtl/hnd_front.sv =====
// Front end: NRZI decode and flag detection, one classified bit per accepted beat.
module hnd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              line_level,
  output logic              push,
  output hnd_pkg::hnd_evt_t push_evt,
  input  logic              queue_full
);
  import hnd_pkg::*;

  logic       prev_level_r, prev_level_nxt;
  logic [7:0] window_r, window_nxt;
  logic       dec_bit;

  // Accept whenever the queue has room
  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Decode: no level change means a one
  always_comb begin
    dec_bit        = (line_level == prev_level_r);
    prev_level_nxt = prev_level_r;
    window_nxt     = window_r;
    if (push) begin
      prev_level_nxt = line_level;
      window_nxt     = {dec_bit, window_r[7:1]};
    end
  end

  // Classify the new bit
  assign push_evt.is_flag = ({dec_bit, window_r[7:1]} == FLAG_BYTE);
  assign push_evt.bit_val = dec_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      window_r     <= WINDOW_RESET;
    end else begin
      prev_level_r <= prev_level_nxt;
      window_r     <= window_nxt;
    end
  end

endmodule

// ===== rtl/hnd_queue.sv =====
// Short event queue between front and back.
module hnd_queue #(
  parameter int unsigned DEPTH = hnd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hnd_pkg::hnd_evt_t push_evt,
  output logic              full,
  input  logic              pop,
  output hnd_pkg::hnd_evt_t pop_evt,
  output logic              empty
);
  import hnd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hnd_evt_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign pop_evt = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_evt;
    end
  end

endmodule

// ===== rtl/hnd_back.sv =====
// Back end: destuffing, abort, byte packing, CRC, length check and result register.
module hnd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [hnd_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                     queue_empty,
  input  hnd_pkg::hnd_evt_t        evt,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hnd_pkg::hnd_result_t     result
);
  import hnd_pkg::*;

  logic [LEN_W-1:0] max_bytes_r;
  logic             inside_r, inside_nxt;
  logic [2:0]       ones_r, ones_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic [7:0]       partial_r, partial_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic             out_valid_r, out_valid_nxt;
  hnd_result_t      result_r;
  hnd_result_t      emit_res;
  logic             emit;
  logic [7:0]       full_byte;
  hnd_status_t      end_status;

  assign pop       = !queue_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Byte as it stands once the current bit is added
  always_comb begin
    full_byte = partial_r;
    full_byte[bit_idx_r] = evt.bit_val;
  end

  // Status of a frame closed by a flag
  always_comb begin
    priority if (total_r < MIN_FRAME_BYTES) begin
      end_status = ST_SHORT;
    end else if (bit_idx_r != 3'd7) begin
      end_status = ST_ALIGN;
    end else if (crc_r == CRC_GOOD) begin
      end_status = ST_GOOD;
    end else begin
      end_status = ST_CRC;
    end
  end

  // Carry out one event
  always_comb begin
    inside_nxt  = inside_r;
    ones_nxt    = ones_r;
    bit_idx_nxt = bit_idx_r;
    partial_nxt = partial_r;
    crc_nxt     = crc_r;
    total_nxt   = total_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    emit        = 1'b0;
    emit_res    = '{is_end: 1'b1, data_byte: 8'h00, status: ST_GOOD, length: '0};
    if (pop) begin
      if (evt.is_flag) begin
        // Close any frame, then open a new one unless the closed frame was good
        if (inside_r && (total_r != '0)) begin
          emit            = 1'b1;
          emit_res.status = end_status;
          if (end_status == ST_GOOD) begin
            emit_res.length = total_r - CRC_BYTES;
          end
        end
        inside_nxt  = !(inside_r && (total_r != '0) && (end_status == ST_GOOD));
        total_nxt   = '0;
        bit_idx_nxt = '0;
        partial_nxt = '0;
        crc_nxt     = CRC_PRESET;
        ones_nxt    = '0;
      end else if (inside_r) begin
        if (evt.bit_val && (ones_r == 3'd6)) begin
          // Seven ones: abort
          ones_nxt   = '0;
          inside_nxt = 1'b0;
          if (total_r != '0) begin
            emit            = 1'b1;
            emit_res.status = ST_ABORT;
          end
        end else if (!evt.bit_val && (ones_r == 3'd5)) begin
          // Drop the stuffed zero
          ones_nxt = '0;
        end else begin
          ones_nxt    = evt.bit_val ? ones_r + 1'b1 : 3'd0;
          bit_idx_nxt = bit_idx_r + 1'b1;
          partial_nxt = full_byte;
          if (bit_idx_r == 3'd7) begin
            partial_nxt = '0;
            if (total_r >= max_bytes_r) begin
              inside_nxt      = 1'b0;
              emit            = 1'b1;
              emit_res.status = ST_LONG;
            end else begin
              crc_nxt   = crc_byte(crc_r, full_byte);
              held0_nxt = held1_r;
              held1_nxt = full_byte;
              total_nxt = total_r + 1'b1;
              if (total_r >= CRC_BYTES) begin
                emit               = 1'b1;
                emit_res.is_end    = 1'b0;
                emit_res.data_byte = held0_r;
              end
            end
          end
        end
      end
    end
  end

  // Hold or release the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_FRAME_RESET;
      inside_r    <= 1'b0;
      ones_r      <= '0;
      bit_idx_r   <= '0;
      partial_r   <= '0;
      crc_r       <= CRC_PRESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_bytes_r <= cfg_wr_data;
      end
      inside_r    <= inside_nxt;
      ones_r      <= ones_nxt;
      bit_idx_r   <= bit_idx_nxt;
      partial_r   <= partial_nxt;
      crc_r       <= crc_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    if (emit) begin
      result_r <= emit_res;
    end
  end

endmodule

// ===== sim/deframe_check_pkg.sv =====
// Scoreboard class for the HDLC NRZI deframer: line bit predictor and result checker.
package deframe_check_pkg;
  import hnd_pkg::*;

  class deframe_scoreboard;
    logic [LEN_W-1:0] frame_limit;
    bit               prev_line;
    bit [7:0]         flag_shift;
    bit [2:0]         ones_count;
    bit               frame_open;
    bit [2:0]         bit_pos;
    bit [7:0]         shift_byte;
    bit [15:0]        fcs;
    bit [LEN_W-1:0]   byte_count;
    bit [7:0]         delay_line [2];
    hnd_result_t      expected_beats [$];
    int unsigned      errors;
    int unsigned      data_beats;
    int unsigned      end_beats [6];

    function new();
      frame_limit = MAX_FRAME_RESET;
      prev_line   = 1'b0;
      flag_shift  = WINDOW_RESET;
      ones_count  = '0;
      frame_open  = 1'b0;
      bit_pos     = '0;
      shift_byte  = '0;
      fcs         = CRC_PRESET;
      byte_count  = '0;
      errors      = 0;
      data_beats  = 0;
      foreach (end_beats[i]) end_beats[i] = 0;
    endfunction

    // Advance the reflected CRC-CCITT by one byte, LSB first
    static function bit [15:0] fcs_step(bit [15:0] c, bit [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void restart_frame();
      frame_open = 1'b1;
      byte_count = '0;
      bit_pos    = '0;
      shift_byte = '0;
      fcs        = CRC_PRESET;
      ones_count = '0;
    endfunction

    function void push_end(hnd_status_t st, logic [LEN_W-1:0] len);
      hnd_result_t r;
      r           = '0;
      r.is_end    = 1'b1;
      r.status    = st;
      r.length    = len;
      expected_beats.push_back(r);
    endfunction

    // Decode one accepted line level and queue the beat it causes, if any
    function void note_level(bit level);
      bit          d;
      bit [7:0]    b;
      hnd_status_t st;
      hnd_result_t r;
      d          = (level == prev_line);
      prev_line  = level;
      flag_shift = {d, flag_shift[7:1]};

      // Flag: close the current frame or open a new one
      if (flag_shift == FLAG_BYTE) begin
        if (frame_open && byte_count != 0) begin
          if (byte_count < MIN_FRAME_BYTES) st = ST_SHORT;
          else if (bit_pos != 3'd7) st = ST_ALIGN;
          else if (fcs == CRC_GOOD) st = ST_GOOD;
          else st = ST_CRC;
          push_end(st, (st == ST_GOOD) ? byte_count - CRC_BYTES : '0);
          restart_frame();
          if (st == ST_GOOD) frame_open = 1'b0;
        end else begin
          restart_frame();
        end
        return;
      end

      if (!frame_open) return;

      // Track runs of ones: abort at seven, drop the stuffed zero after five
      if (d) begin
        ones_count++;
        if (ones_count == 3'd7) begin
          ones_count = '0;
          frame_open = 1'b0;
          if (byte_count != 0) push_end(ST_ABORT, '0);
          return;
        end
      end else begin
        if (ones_count == 3'd5) begin
          ones_count = '0;
          return;
        end
        ones_count = '0;
      end

      // Pack LSB first
      shift_byte[bit_pos] = d;
      bit_pos++;
      if (bit_pos != 0) return;

      b          = shift_byte;
      shift_byte = '0;
      if (byte_count >= frame_limit) begin
        frame_open = 1'b0;
        push_end(ST_LONG, '0);
        return;
      end
      fcs = fcs_step(fcs, b);

      // Release the byte from two bytes back
      if (byte_count >= 2) begin
        r           = '0;
        r.data_byte = delay_line[0];
        expected_beats.push_back(r);
      end
      delay_line[0] = delay_line[1];
      delay_line[1] = b;
      byte_count++;
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got, time t);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", t, name, want, got);
      end
    endfunction

    // Check one accepted result beat against the oldest expectation
    function void check_beat(logic is_end, logic [23:0] data, time t);
      hnd_result_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected, expected none, actual tuser=%b tdata=%h",
                 t, is_end, data);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("is_frame_end", want.is_end, is_end, t);
      compare_field("data_byte", want.data_byte, data[7:0], t);
      compare_field("frame_status", want.status, data[10:8], t);
      compare_field("frame_length", want.length, data[22:11], t);
      compare_field("pad bit", 12'd0, data[23], t);
      if (want.is_end) end_beats[want.status]++;
      else data_beats++;
    endfunction

    function int unsigned outstanding();
      return expected_beats.size();
    endfunction
  endclass

endpackage

// ===== sim/tb.sv =====
// Testbench top for the HDLC NRZI deframer: frame generator, drivers and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hnd_pkg::*;
  import deframe_check_pkg::*;

  // Idle limit, far longer than any legal run without a beat
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_BITS   = 140;

  typedef enum {FR_GOOD, FR_BAD_FCS, FR_SHORT, FR_MISALIGNED, FR_ABORT, FR_OVERSIZE}
    frame_kind_t;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata    = '0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [23:0]      out_tdata;
  logic             out_tuser;

  deframe_scoreboard sb = new();

  bit          line_now    = 1'b0;
  int          stuff_run   = 0;
  bit          steady      = 1'b0;
  int unsigned bits_sent   = 0;
  int unsigned idle_cycles = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  hdlc_nrzi_deframer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Check result beats and stall the receiver at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tuser, out_tdata, $time);
    out_tready <= steady || ($urandom_range(0, 99) >= 15);
  end

  // End the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one line level and hold it until accepted
  task automatic send_level(input bit lvl);
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, lvl};
    do @(posedge clk); while (!in_tready);
    sb.note_level(lvl);
    line_now = lvl;
    bits_sent++;
  endtask

  // NRZI: a one keeps the level, a zero toggles it
  task automatic send_bit(input bit d);
    send_level(d ? line_now : !line_now);
  endtask

  task automatic send_flag();
    for (int i = 0; i < 8; i++) send_bit(FLAG_BYTE[i]);
    stuff_run = 0;
  endtask

  // Insert a zero after five data ones
  task automatic send_data_bit(input bit d);
    send_bit(d);
    stuff_run = d ? stuff_run + 1 : 0;
    if (stuff_run == 5) begin
      send_bit(1'b0);
      stuff_run = 0;
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_level(1'($urandom_range(0, 1)));
    stuff_run = 0;
  endtask

  // Hold the sender until every expected beat has come, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sb.frame_limit  = v;
  endtask

  // Build one frame of the given kind and send it with its flags
  task automatic send_frame(input frame_kind_t kind, input int payload_len, input int openers);
    bit [7:0]  body [$];
    bit [7:0]  b;
    bit [15:0] crc;
    int        pick;
    crc = CRC_PRESET;
    for (int k = 0; k < payload_len; k++) begin
      pick = $urandom_range(0, 19);
      b    = (pick == 0) ? 8'hFF : (pick == 1) ? FLAG_BYTE : (pick == 2) ? 8'h00
                                                                      : 8'($urandom);
      body.push_back(b);
      crc = deframe_scoreboard::fcs_step(crc, b);
    end
    crc = ~crc;
    if (kind == FR_BAD_FCS) crc[$urandom_range(0, 15)] ^= 1'b1;
    if (kind == FR_GOOD || kind == FR_BAD_FCS || kind == FR_MISALIGNED) begin
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    repeat (openers) send_flag();
    stuff_run = 0;
    foreach (body[i]) begin
      for (int j = 0; j < 8; j++) send_data_bit(body[i][j]);
    end
    if (kind == FR_MISALIGNED) begin
      repeat ($urandom_range(1, 7)) send_data_bit(1'($urandom_range(0, 1)));
    end
    if (kind == FR_ABORT) begin
      repeat ($urandom_range(7, 12)) send_bit(1'b1);
      stuff_run = 0;
    end else begin
      send_flag();
    end
  endtask

  // Mostly well formed frames with random content, the rest broken frames and noise
  task automatic run_random(input int unsigned nbits);
    int unsigned stop;
    int          pick;
    int          len;
    frame_kind_t kind;
    stop = bits_sent + nbits;
    while (bits_sent < stop) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(2, 14);
      kind = FR_GOOD;
      if (pick >= 68 && pick < 74) kind = FR_BAD_FCS;
      else if (pick >= 74 && pick < 79) begin
        kind = FR_SHORT;
        len  = $urandom_range(1, 3);
      end else if (pick >= 79 && pick < 84) kind = FR_MISALIGNED;
      else if (pick >= 84 && pick < 89) begin
        kind = FR_ABORT;
        len  = $urandom_range(0, 8);
      end else if (pick >= 89 && pick < 94 && sb.frame_limit <= 64) begin
        kind = FR_OVERSIZE;
        len  = sb.frame_limit + $urandom_range(1, 4);
      end
      if (pick >= 94) send_noise($urandom_range(4, 40));
      else send_frame(kind, len, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2));
      if ($urandom_range(0, 3) == 0) send_flag();
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases at the reset size limit
    repeat (3) send_flag();
    send_frame(FR_GOOD, 2, 1);
    send_frame(FR_GOOD, 20, 2);
    send_frame(FR_BAD_FCS, 6, 1);
    send_frame(FR_SHORT, 1, 1);
    send_frame(FR_SHORT, 3, 1);
    send_frame(FR_MISALIGNED, 4, 1);
    send_frame(FR_ABORT, 0, 1);
    send_frame(FR_ABORT, 5, 1);
    send_frame(FR_GOOD, 4, 1);
    // no opening flag after a good end: bytes are ignored
    send_frame(FR_GOOD, 4, 0);
    send_noise(40);

    // Smallest limit: exact fit, then frames one byte too long
    write_limit(12'd4);
    send_frame(FR_GOOD, 2, 1);
    send_frame(FR_OVERSIZE, 5, 1);
    send_frame(FR_GOOD, 3, 1);
    run_random(RANDOM_BITS);

    // Largest limit: one long frame with no idling on either side
    write_limit(12'd4095);
    steady = 1'b1;
    send_frame(FR_GOOD, 30, 1);
    in_tvalid <= 1'b0;
    @(posedge clk);
    steady = 1'b0;
    run_random(RANDOM_BITS);

    write_limit(12'($urandom_range(5, 60)));
    run_random(RANDOM_BITS);

    write_limit(MAX_FRAME_RESET);
    run_random(RANDOM_BITS);

    drain();
    $display("Sent %0d line bits; checked %0d data bytes and frame ends:", bits_sent,
             sb.data_beats);
    $display("  good %0d, crc %0d, short %0d, misaligned %0d, aborted %0d, too long %0d",
             sb.end_beats[ST_GOOD], sb.end_beats[ST_CRC], sb.end_beats[ST_SHORT],
             sb.end_beats[ST_ALIGN], sb.end_beats[ST_ABORT], sb.end_beats[ST_LONG]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hnd_pkg.sv
rtl/hnd_front.sv
rtl/hnd_queue.sv
rtl/hnd_back.sv
rtl/hdlc_nrzi_deframer.sv
sim/deframe_check_pkg.sv
sim/tb.sv
